/* design/bounded_list_push_search_macros.svh */
// ----------------------------------------------------------------------------
// bounded_list_push_search_macros
// assertion macros used by the list engine top module
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_PUSH_SEARCH_MACROS_SVH
`define BOUNDED_LIST_PUSH_SEARCH_MACROS_SVH

// property checked at every clock edge outside reset
`define BLS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// types, constants and helpers for the bounded list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bls_pkg;

	localparam int DEPTH  = 64;
	localparam int WW     = 64;
	localparam int PW     = $clog2(DEPTH);
	localparam int CW     = PW + 1;
	localparam int GRP    = 8;
	localparam int GW     = $clog2(GRP);
	localparam int NGRP   = DEPTH / GRP;
	localparam int NGW    = PW - GW;

	localparam logic [WW-1:0] EXP_MASK = 64'h7FF0_0000_0000_0000;
	localparam logic [WW-1:0] MAN_MASK = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [WW-1:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_GET_INDEX  = 3'd2,
		ACT_GET_FRONT  = 3'd3,
		ACT_GET_END    = 3'd4,
		ACT_FIND       = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic          push_front;
		logic          push_back;
		logic [CW-1:0] wr_count;
		logic          rd_en;
		logic          rd_find;
		logic [CW-1:0] rd_count;
		logic [PW-1:0] target;
	} cell_ctrl_t;

	function automatic logic is_nan(input logic [WW-1:0] w);
		return ((w & EXP_MASK) == EXP_MASK) && ((w & MAN_MASK) != '0);
	endfunction

	// ieee equality on raw double patterns
	function automatic logic dbl_eq(input logic [WW-1:0] a, input logic [WW-1:0] b);
		logic res;
		if (is_nan(a) || is_nan(b))
			res = 1'b0;
		else if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0))
			res = 1'b1;
		else
			res = (a == b);
		return res;
	endfunction

endpackage

/* design/bls_intf.sv */
// ----------------------------------------------------------------------------
// bls_intf
// valid/ready channels for list requests and responses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bls_req_if import bls_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [2:0]    action;
	logic [WW-1:0] value;
	logic [PW-1:0] index;

	modport source (output valid, output action, output value, output index, input ready);
	modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface bls_rsp_if import bls_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [WW-1:0] data;
	logic [PW-1:0] position;
	logic [1:0]    status;
	logic [CW-1:0] count;

	modport source (output valid, output data, output position, output status, output count,
		input ready);
	modport sink   (input valid, input data, input position, input status, input count,
		output ready);
endinterface

/* design/bounded_list_push_search.sv */
// ----------------------------------------------------------------------------
// bounded_list_push_search
// bounded ordered list of 64-bit words with push, get and linear find
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req       in    valid/ready    action, value, index
//  rsp       out   valid/ready    data, position, status, count
//  cfg       in    cfg_we         cfg_wdata (capacity)
//
// one transaction at a time through accept, per-cell compare, group select,
// final select into the output register; the next request is taken once
// the current one has reached the output register.
// pushes update the cell row at the accept edge.
// reset clears the count and sets capacity to 64; stored words are not cleared.
// a stalled response holds in the output register while a new request proceeds.
`timescale 1ns / 1ps

module bounded_list_push_search import bls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_wdata,
	bls_req_if.sink       req,
	bls_rsp_if.source     rsp
);

	`include "bounded_list_push_search_macros.svh"

	logic [CW-1:0] capacity_q;
	logic [CW-1:0] entry_count_q;

	logic          v_s1, v_s2, v_s3;
	logic          find_s1, find_s2, find_s3;
	logic          get_s1, get_s2, get_s3;
	status_t       status_s1, status_s2, status_s3;
	logic [CW-1:0] count_s1, count_s2, count_s3;
	logic [WW-1:0] key_s1;
	logic [PW-1:0] target_s1;

	logic          out_v_q;
	logic [WW-1:0] out_data_q;
	logic [PW-1:0] out_pos_q;
	status_t       out_status_q;
	logic [CW-1:0] out_count_q;

	logic          acc, move;
	logic [CW-1:0] limit;
	logic          full;
	logic          do_pb, do_pf, is_find, is_get;
	status_t       acc_status;
	logic [PW-1:0] acc_target;
	logic [CW-1:0] next_count;
	cell_ctrl_t    ctrl;

	logic [DEPTH-1:0]         cell_hit;
	logic [DEPTH-1:0][WW-1:0] cell_data;
	logic [DEPTH-1:0][WW-1:0] cell_word;
	logic [NGRP-1:0]          grp_any;
	logic [NGRP-1:0][GW-1:0]  grp_lpos;
	logic [NGRP-1:0][WW-1:0]  grp_data;

	logic          fin_any;
	logic [NGW-1:0] fin_grp;
	logic [PW-1:0] fin_pos;
	logic [WW-1:0] fin_data;
	status_t       fin_status;

	assign acc       = req.valid && req.ready;
	assign req.ready = !(v_s1 || v_s2 || v_s3);
	assign move      = v_s3 && (!out_v_q || rsp.ready);

	assign limit = (capacity_q > CW'(DEPTH)) ? CW'(DEPTH) : capacity_q;
	assign full  = (entry_count_q >= limit);

	always_comb begin
		do_pb      = 1'b0;
		do_pf      = 1'b0;
		is_find    = 1'b0;
		is_get     = 1'b0;
		acc_status = ST_OK;
		acc_target = req.index;
		case (req.action)
			ACT_PUSH_BACK: begin
				if (full) acc_status = ST_FULL;
				else      do_pb = 1'b1;
			end
			ACT_PUSH_FRONT: begin
				if (full) acc_status = ST_FULL;
				else      do_pf = 1'b1;
			end
			ACT_GET_INDEX: begin
				is_get = 1'b1;
				if ({1'b0, req.index} >= entry_count_q) acc_status = ST_RANGE;
			end
			ACT_GET_FRONT: begin
				is_get     = 1'b1;
				acc_target = '0;
				if (entry_count_q == '0) acc_status = ST_RANGE;
			end
			ACT_GET_END: begin
				is_get     = 1'b1;
				acc_target = PW'(entry_count_q - CW'(1));
				if (entry_count_q == '0) acc_status = ST_RANGE;
			end
			ACT_FIND: begin
				is_find = 1'b1;
			end
			default: begin
			end
		endcase
		next_count = (do_pb || do_pf) ? entry_count_q + CW'(1) : entry_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= CW'(DEPTH);
			entry_count_q <= '0;
		end else begin
			if (cfg_we)
				capacity_q <= cfg_wdata;
			if (acc)
				entry_count_q <= next_count;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (v_s2)
				v_s3 <= 1'b1;
			else if (move)
				v_s3 <= 1'b0;
			if (move)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			find_s1   <= is_find;
			get_s1    <= is_get;
			status_s1 <= acc_status;
			count_s1  <= next_count;
			key_s1    <= req.value;
			target_s1 <= acc_target;
		end
		if (v_s1) begin
			find_s2   <= find_s1;
			get_s2    <= get_s1;
			status_s2 <= status_s1;
			count_s2  <= count_s1;
		end
		if (v_s2) begin
			find_s3   <= find_s2;
			get_s3    <= get_s2;
			status_s3 <= status_s2;
			count_s3  <= count_s2;
		end
	end

	always_comb begin
		ctrl.push_front = acc && do_pf;
		ctrl.push_back  = acc && do_pb;
		ctrl.wr_count   = entry_count_q;
		ctrl.rd_en      = v_s1;
		ctrl.rd_find    = find_s1;
		ctrl.rd_count   = count_s1;
		ctrl.target     = target_s1;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bls_cell u_cell (
			.clk       (clk),
			.pos       (PW'(i)),
			.ctrl      (ctrl),
			.wr_value  (req.value),
			.rd_key    (key_s1),
			.left_word ((i == 0) ? '0 : cell_word[(i == 0) ? 0 : i - 1]),
			.word      (cell_word[i]),
			.hit       (cell_hit[i]),
			.hit_data  (cell_data[i])
		);
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		bls_group u_group (
			.clk      (clk),
			.en       (v_s2),
			.hit      (cell_hit[g*GRP +: GRP]),
			.data     (cell_data[g*GRP +: GRP]),
			.any      (grp_any[g]),
			.lpos     (grp_lpos[g]),
			.sel_data (grp_data[g])
		);
	end

	// lowest group holding a hit
	always_comb begin
		fin_grp = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any[g])
				fin_grp = NGW'(g);
		end
		fin_any = |grp_any;
		fin_pos = {fin_grp, grp_lpos[fin_grp]};
		fin_data = (get_s3 && (status_s3 == ST_OK)) ? grp_data[fin_grp] : '0;
		if (find_s3)
			fin_status = fin_any ? ST_OK : ST_NOTFOUND;
		else
			fin_status = status_s3;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q   <= fin_data;
			out_pos_q    <= (find_s3 && fin_any) ? fin_pos : '0;
			out_status_q <= fin_status;
			out_count_q  <= count_s3;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.data     = out_data_q;
	assign rsp.position = out_pos_q;
	assign rsp.status   = out_status_q;
	assign rsp.count    = out_count_q;

	`BLS_ASSERT(a_one_in_flight, $onehot0({v_s1, v_s2, v_s3}), "more than one transaction in flight")
	`BLS_ASSERT(a_count_bound, entry_count_q <= CW'(DEPTH), "entry count above depth")
	`BLS_ASSERT_NEXT(a_s1_to_s2, v_s1, v_s2, "compare stage did not advance")
	`BLS_ASSERT_NEXT(a_push_grows, acc && (do_pb || do_pf), entry_count_q == $past(entry_count_q) + CW'(1), "push did not grow the list")
	`BLS_ASSERT(a_no_accept_busy, (v_s1 || v_s2 || v_s3) |-> !req.ready, "request taken while busy")

endmodule

/* design/bls_cell.sv */
// ----------------------------------------------------------------------------
// bls_cell
// one list slot: holds a word, shifts from its neighbor, flags a hit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_cell import bls_pkg::*; (
	input  logic          clk,
	input  logic [PW-1:0] pos,
	input  cell_ctrl_t    ctrl,
	input  logic [WW-1:0] wr_value,
	input  logic [WW-1:0] rd_key,
	input  logic [WW-1:0] left_word,
	output logic [WW-1:0] word,
	output logic          hit,
	output logic [WW-1:0] hit_data
);

	logic [WW-1:0] word_q;
	logic          hit_s2;
	logic [WW-1:0] data_s2;
	logic          in_list;

	assign in_list = ({1'b0, pos} < ctrl.rd_count);

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			word_q <= (pos == '0) ? wr_value : left_word;
		end else if (ctrl.push_back && ({1'b0, pos} == ctrl.wr_count)) begin
			word_q <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			hit_s2  <= ctrl.rd_find ? (in_list && dbl_eq(word_q, rd_key)) : (pos == ctrl.target);
			data_s2 <= word_q;
		end
	end

	assign word     = word_q;
	assign hit      = hit_s2;
	assign hit_data = data_s2;

endmodule

/* design/bls_group.sv */
// ----------------------------------------------------------------------------
// bls_group
// lowest-hit select over one group of cells, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_group import bls_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [GRP-1:0]          hit,
	input  logic [GRP-1:0][WW-1:0]  data,
	output logic                    any,
	output logic [GW-1:0]           lpos,
	output logic [WW-1:0]           sel_data
);

	logic          any_s3;
	logic [GW-1:0] lpos_s3;
	logic [WW-1:0] data_s3;
	logic [GW-1:0] pick;

	// descending walk leaves the lowest hit selected
	always_comb begin
		pick = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (hit[i])
				pick = GW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			any_s3  <= |hit;
			lpos_s3 <= pick;
			data_s3 <= data[pick];
		end
	end

	assign any      = any_s3;
	assign lpos     = lpos_s3;
	assign sel_data = data_s3;

endmodule
